FILE: hdl/pns_pkg.sv
// shared types, op codes and widths for the palette nearest color search
package pns_pkg;

	localparam int PAL_DEPTH = 256;
	localparam int CH_W      = 8;
	localparam int IDX_W     = 8;
	localparam int DIST_W    = 10;
	localparam int COLOR_W   = 4 * CH_W;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_FIND  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	typedef struct packed {
		logic [1:0]       op;
		logic [IDX_W-1:0] entry_index;
		logic [CH_W-1:0]  alpha_in;
		logic [CH_W-1:0]  red_in;
		logic [CH_W-1:0]  green_in;
		logic [CH_W-1:0]  blue_in;
		logic             mark_valid;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0]  found_index;
		logic [CH_W-1:0]   alpha_out;
		logic [CH_W-1:0]   red_out;
		logic [CH_W-1:0]   green_out;
		logic [CH_W-1:0]   blue_out;
		logic              entry_present;
		logic [DIST_W-1:0] best_distance;
		logic              no_base_entry;
	} rsp_t;

endpackage

FILE: hdl/pns_if.sv
// valid/ready channel interfaces for requests and responses

interface pns_req_if import pns_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pns_rsp_if import pns_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/pns_ram.sv
// generic single write port RAM with registered read
module pns_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/pns_dist.sv
// shared L1 distance unit over four 8-bit channels, registered output
module pns_dist import pns_pkg::*; (
	input  logic               clk,
	input  logic [COLOR_W-1:0] ref_color,
	input  logic [COLOR_W-1:0] ent_color,
	output logic [DIST_W-1:0]  dist_s2
);

	logic [CH_W-1:0]   diff [4];
	logic [DIST_W-1:0] sum;

	// per-channel absolute difference
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			if (ref_color[c*CH_W +: CH_W] >= ent_color[c*CH_W +: CH_W]) begin
				diff[c] = ref_color[c*CH_W +: CH_W] - ent_color[c*CH_W +: CH_W];
			end else begin
				diff[c] = ent_color[c*CH_W +: CH_W] - ref_color[c*CH_W +: CH_W];
			end
		end
		sum = DIST_W'(diff[0]) + DIST_W'(diff[1]) + DIST_W'(diff[2]) + DIST_W'(diff[3]);
	end

	always_ff @(posedge clk) begin
		dist_s2 <= sum;
	end

endmodule

FILE: hdl/palette_nearest_color_search_core.sv
// top level: palette store, scan sequencer and result register
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+----------------------------------------
//  req     | in  | valid / ready    | op, entry_index, argb in, mark_valid
//  rsp     | out | valid / ready    | found_index, argb out, present, dist
//
// write, unused ops and find without a marked entry 0: result valid in the cycle after the transfer
// read: the registered palette RAM read, then the result register
// find: one entry per cycle through the RAM read and distance stages, then the result register
// reset clears all valid marks at once; colors in RAM are not cleared
// req.ready is low while an op is in flight or the result register is held
module palette_nearest_color_search_core import pns_pkg::*; #(
	parameter int PALETTE_DEPTH = PAL_DEPTH
) (
	input logic        clk,
	input logic        arst_n,
	pns_req_if.sink    req,
	pns_rsp_if.source  rsp
);

	localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam logic [IDX_W:0] DEPTH_LIM = (IDX_W+1)'(PALETTE_DEPTH);
	localparam logic [AW-1:0]  LAST_IDX  = AW'(PALETTE_DEPTH - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_READ  = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	logic [1:0]               state_q;
	logic [PALETTE_DEPTH-1:0] valid_q;
	logic [AW-1:0]            cnt_q;
	logic [COLOR_W-1:0]       color_q;
	logic [IDX_W-1:0]         idx_q;
	logic                     present_q;
	logic                     live_s1, live_s2;
	logic                     vld_s1, vld_s2;
	logic [AW-1:0]            idx_s1, idx_s2;
	logic [DIST_W-1:0]        best_q;
	logic [AW-1:0]            bestidx_q;
	logic                     out_valid_q;
	rsp_t                     out_q;

	logic               accept;
	logic               out_free;
	logic               in_range;
	logic [AW-1:0]      in_addr;
	logic [COLOR_W-1:0] in_color;
	logic               ram_we;
	logic [AW-1:0]      ram_raddr;
	logic [COLOR_W-1:0] ram_rdata;
	logic [DIST_W-1:0]  dist_s2;
	logic               out_load;
	rsp_t               out_next;
	logic               scan_done;

	// handshake
	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && out_free;
	assign accept    = req.valid && req.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// request decode
	assign in_range  = {1'b0, req.data.entry_index} < DEPTH_LIM;
	assign in_addr   = req.data.entry_index[AW-1:0];
	assign in_color  = {req.data.alpha_in, req.data.red_in, req.data.green_in,
		req.data.blue_in};
	assign scan_done = (state_q == ST_DRAIN) && !live_s1 && !live_s2;
	assign ram_raddr = (state_q == ST_SCAN) ? cnt_q : in_addr;

	pns_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (PALETTE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (in_addr),
		.wdata (in_color),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pns_dist u_dist (
		.clk       (clk),
		.ref_color (color_q),
		.ent_color (ram_rdata),
		.dist_s2   (dist_s2)
	);

	// result selection and RAM write enable
	always_comb begin
		ram_we   = 1'b0;
		out_load = 1'b0;
		out_next = '0;
		out_next.found_index = req.data.entry_index;
		if (accept) begin
			case (req.data.op)
				OP_WRITE: begin
					ram_we   = in_range && req.data.mark_valid;
					out_load = 1'b1;
				end
				OP_FIND: begin
					if (!valid_q[0]) begin
						out_load = 1'b1;
						out_next.found_index   = '0;
						out_next.no_base_entry = 1'b1;
					end
				end
				OP_READ: begin
					out_load = 1'b0;
				end
				default: begin
					out_load = 1'b1;
				end
			endcase
		end else if (state_q == ST_READ) begin
			out_load = 1'b1;
			out_next.found_index = idx_q;
			if (present_q) begin
				out_next.alpha_out     = ram_rdata[4*CH_W-1:3*CH_W];
				out_next.red_out       = ram_rdata[3*CH_W-1:2*CH_W];
				out_next.green_out     = ram_rdata[2*CH_W-1:CH_W];
				out_next.blue_out      = ram_rdata[CH_W-1:0];
				out_next.entry_present = 1'b1;
			end
		end else if (scan_done) begin
			out_load = 1'b1;
			out_next.found_index   = IDX_W'(bestidx_q);
			out_next.best_distance = best_q;
		end
	end

	// sequencer, valid marks and scan pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			live_s1     <= 1'b0;
			live_s2     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			live_s1 <= (state_q == ST_SCAN);
			live_s2 <= live_s1;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.data.op == OP_WRITE && in_range) begin
							valid_q[in_addr] <= req.data.mark_valid;
						end
						if (req.data.op == OP_READ) begin
							state_q <= ST_READ;
						end
						if (req.data.op == OP_FIND && valid_q[0]) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (cnt_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (scan_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q     <= req.data.entry_index;
			present_q <= in_range && valid_q[in_addr];
			color_q   <= in_color;
			cnt_q     <= '0;
		end else if (state_q == ST_SCAN) begin
			cnt_q <= cnt_q + 1'b1;
		end
		// entry tags follow the RAM read and distance stages
		vld_s1 <= valid_q[cnt_q];
		idx_s1 <= cnt_q;
		vld_s2 <= vld_s1;
		idx_s2 <= idx_s1;
		// running minimum, entry zero seeds it, strict less keeps lowest index on ties
		if (live_s2 && vld_s2 && (idx_s2 == '0 || dist_s2 < best_q)) begin
			best_q    <= dist_s2;
			bestidx_q <= idx_s2;
		end
		if (out_load) begin
			out_q <= out_next;
		end
	end

endmodule

FILE: test/tb.sv
// self-checking testbench for the palette nearest color search core
module tb;
	import pns_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int RANDOM_ITEMS   = 400;
	localparam int IDLE_PERCENT   = 18;
	localparam int CALM_FIRST     = 180;
	localparam int CALM_LAST      = 260;
	localparam int BACKLOG_AT     = 100;
	localparam int BACKLOG_CYCLES = 400;
	localparam int DRAIN_CYCLES   = 300;
	localparam int WATCHDOG_LIMIT = 3000;

	logic clk = 1'b0;
	logic arst_n;

	pns_req_if req_ch ();
	pns_rsp_if rsp_ch ();

	palette_nearest_color_search_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow palette kept in step with accepted requests
	logic [COLOR_W-1:0] palette_argb [PAL_DEPTH];
	logic               palette_live [PAL_DEPTH];

	req_t requests_to_send [$];
	rsp_t answers_due [$];

	int errors        = 0;
	int results_seen  = 0;
	int quiet_cycles  = 0;
	int stall_left    = 0;
	logic backlog_done = 1'b0;
	logic req_taken    = 1'b0;
	logic calm;

	assign calm = (results_seen >= CALM_FIRST) && (results_seen < CALM_LAST);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sum of absolute channel differences between two argb words
	function automatic int unsigned argb_l1(logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b);
		int unsigned sum;
		int ca, cb;
		sum = 0;
		for (int k = 0; k < 4; k++) begin
			ca = int'(a[CH_W*k +: CH_W]);
			cb = int'(b[CH_W*k +: CH_W]);
			sum += (ca >= cb) ? (ca - cb) : (cb - ca);
		end
		return sum;
	endfunction

	// applies one request to the shadow palette and returns the answer it gives
	function automatic rsp_t palette_result(req_t r);
		rsp_t res;
		logic [COLOR_W-1:0] query;
		int unsigned best, cand_dist;
		res = '0;
		res.found_index = r.entry_index;
		query = {r.alpha_in, r.red_in, r.green_in, r.blue_in};
		case (r.op)
			OP_WRITE: begin
				if (int'(r.entry_index) < PAL_DEPTH) begin
					if (r.mark_valid) begin
						palette_argb[r.entry_index] = query;
						palette_live[r.entry_index] = 1'b1;
					end else begin
						palette_live[r.entry_index] = 1'b0;
					end
				end
			end
			OP_FIND: begin
				res.found_index = '0;
				if (!palette_live[0]) begin
					res.no_base_entry = 1'b1;
				end else begin
					best = argb_l1(query, palette_argb[0]);
					for (int i = 1; i < PAL_DEPTH; i++) begin
						if (palette_live[i]) begin
							cand_dist = argb_l1(query, palette_argb[i]);
							// strict compare keeps the lowest index on a tie
							if (cand_dist < best) begin
								best = cand_dist;
								res.found_index = IDX_W'(i);
							end
						end
					end
					res.best_distance = best[DIST_W-1:0];
				end
			end
			OP_READ: begin
				if (int'(r.entry_index) < PAL_DEPTH && palette_live[r.entry_index]) begin
					{res.alpha_out, res.red_out, res.green_out, res.blue_out} =
						palette_argb[r.entry_index];
					res.entry_present = 1'b1;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic req_t make_req(logic [1:0] op, int idx, logic [31:0] argb, logic mark);
		req_t r;
		r.op = op;
		r.entry_index = IDX_W'(idx);
		{r.alpha_in, r.red_in, r.green_in, r.blue_in} = argb;
		r.mark_valid = mark;
		return r;
	endfunction

	// channel values lean toward extremes and a few shared levels so ties occur
	function automatic logic [CH_W-1:0] pick_channel();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			1: return CH_W'(64 * $urandom_range(1, 3));
			default: return CH_W'($urandom_range(0, 255));
		endcase
	endfunction

	// entry 0 and a small low range come up often, the rest spread wide
	function automatic int pick_entry();
		case ($urandom_range(0, 7))
			0: return 0;
			1, 2, 3: return $urandom_range(0, 15);
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	function automatic req_t random_request();
		req_t r;
		int roll;
		roll = $urandom_range(0, 99);
		r.entry_index = IDX_W'(pick_entry());
		r.alpha_in    = pick_channel();
		r.red_in      = pick_channel();
		r.green_in    = pick_channel();
		r.blue_in     = pick_channel();
		r.mark_valid  = 1'($urandom_range(0, 1));
		if (roll < 35) begin
			r.op = OP_WRITE;
			r.mark_valid = 1'b1;
		end else if (roll < 43) begin
			r.op = OP_WRITE;
			r.mark_valid = 1'b0;
		end else if (roll < 73) begin
			r.op = OP_FIND;
		end else if (roll < 93) begin
			r.op = OP_READ;
		end else begin
			r.op = OP_SPARE;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// request driver: new transfer offered at the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_taken) begin
			if (requests_to_send.size() != 0 &&
				(calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
				req_ch.data  <= requests_to_send.pop_front();
				req_ch.valid <= 1'b1;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// response sink: random stalls plus one long hold to back up the input
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (stall_left != 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else if (!backlog_done && results_seen >= BACKLOG_AT) begin
			rsp_ch.ready <= 1'b0;
			stall_left   <= BACKLOG_CYCLES;
			backlog_done <= 1'b1;
		end else if (calm) begin
			rsp_ch.ready <= 1'b1;
		end else begin
			rsp_ch.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
		end
	end

	// monitor: check results, predict accepted requests, watch for a hang
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (answers_due.size() == 0) begin
					$error("unexpected result transfer, found_index %0d",
						rsp_ch.data.found_index);
					errors++;
				end else begin
					want = answers_due.pop_front();
					check_field("found_index", 16'(want.found_index),
						16'(rsp_ch.data.found_index));
					check_field("alpha_out", 16'(want.alpha_out),
						16'(rsp_ch.data.alpha_out));
					check_field("red_out", 16'(want.red_out),
						16'(rsp_ch.data.red_out));
					check_field("green_out", 16'(want.green_out),
						16'(rsp_ch.data.green_out));
					check_field("blue_out", 16'(want.blue_out),
						16'(rsp_ch.data.blue_out));
					check_field("entry_present", 16'(want.entry_present),
						16'(rsp_ch.data.entry_present));
					check_field("best_distance", 16'(want.best_distance),
						16'(rsp_ch.data.best_distance));
					check_field("no_base_entry", 16'(want.no_base_entry),
						16'(rsp_ch.data.no_base_entry));
				end
				results_seen <= results_seen + 1;
			end
			if (req_ch.valid && req_ch.ready)
				answers_due.push_back(palette_result(req_ch.data));
			req_taken <= req_ch.valid && req_ch.ready;

			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		rsp_ch.ready = 1'b0;
		for (int i = 0; i < PAL_DEPTH; i++) begin
			palette_argb[i] = '0;
			palette_live[i] = 1'b0;
		end

		// directed: empty palette, extremes, ties, emptying, spare op
		requests_to_send.push_back(make_req(OP_FIND, 3, 32'h12345678, 1'b0));
		requests_to_send.push_back(make_req(OP_READ, 0, 32'h00000000, 1'b0));
		requests_to_send.push_back(make_req(OP_SPARE, 255, 32'hFFFFFFFF, 1'b1));
		requests_to_send.push_back(make_req(OP_WRITE, 0, 32'h00000000, 1'b1));
		requests_to_send.push_back(make_req(OP_WRITE, 255, 32'hFFFFFFFF, 1'b1));
		requests_to_send.push_back(make_req(OP_FIND, 0, 32'hFFFFFFFF, 1'b0));
		requests_to_send.push_back(make_req(OP_FIND, 255, 32'h00000000, 1'b1));
		requests_to_send.push_back(make_req(OP_FIND, 9, 32'h80808080, 1'b0));
		requests_to_send.push_back(make_req(OP_WRITE, 7, 32'hFFFFFFFF, 1'b1));
		requests_to_send.push_back(make_req(OP_FIND, 0, 32'hFFFFFFFF, 1'b0));
		requests_to_send.push_back(make_req(OP_WRITE, 0, 32'hFFFFFFFF, 1'b1));
		requests_to_send.push_back(make_req(OP_FIND, 0, 32'h00000000, 1'b0));
		requests_to_send.push_back(make_req(OP_READ, 255, 32'h00000000, 1'b0));
		requests_to_send.push_back(make_req(OP_WRITE, 255, 32'h5A5A5A5A, 1'b0));
		requests_to_send.push_back(make_req(OP_READ, 255, 32'hFFFFFFFF, 1'b1));
		requests_to_send.push_back(make_req(OP_FIND, 0, 32'hFFFFFFFF, 1'b0));
		requests_to_send.push_back(make_req(OP_WRITE, 255, 32'hA5C30F81, 1'b1));
		requests_to_send.push_back(make_req(OP_READ, 255, 32'h00000000, 1'b0));
		requests_to_send.push_back(make_req(OP_WRITE, 0, 32'h00000000, 1'b0));
		requests_to_send.push_back(make_req(OP_FIND, 0, 32'h80808080, 1'b1));
		requests_to_send.push_back(make_req(OP_READ, 0, 32'h00000000, 1'b0));
		requests_to_send.push_back(make_req(OP_WRITE, 0, 32'h00FF00FF, 1'b1));
		requests_to_send.push_back(make_req(OP_READ, 0, 32'h00000000, 1'b0));
		requests_to_send.push_back(make_req(OP_SPARE, 0, 32'h00000000, 1'b0));

		for (int n = 0; n < RANDOM_ITEMS; n++)
			requests_to_send.push_back(random_request());

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		while (requests_to_send.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
